// File: design/euclidean_gcd_unit_assert.svh
// Assertion macros shared by the gcd unit modules.
`ifndef EUCLIDEAN_GCD_UNIT_ASSERT_SVH
`define EUCLIDEAN_GCD_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define EGCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("egcd: same-cycle check failed");

`define EGCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("egcd: next-cycle check failed");

`else

`define EGCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define EGCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: design/egcd_pkg.sv
package egcd_pkg;

  localparam int OPERAND_BITS = 63;
  localparam int CNT_BITS     = $clog2(OPERAND_BITS + 1);

  typedef logic [OPERAND_BITS-1:0] operand_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// File: design/egcd_rem.sv
`include "euclidean_gcd_unit_assert.svh"

// Restoring remainder unit: one dividend bit shifts in per cycle while busy.
module egcd_rem (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  egcd_pkg::operand_t dividend,
  input  egcd_pkg::operand_t divisor,
  output logic              done,
  output egcd_pkg::operand_t remainder
);
  import egcd_pkg::*;

  operand_t dvd_r, dvd_nxt;
  operand_t dsr_r, dsr_nxt;
  operand_t rem_r, rem_nxt;
  cnt_t     cnt_r, cnt_nxt;
  logic     busy_r, busy_nxt;
  logic     done_r, done_nxt;

  logic [OPERAND_BITS:0] trial;
  logic [OPERAND_BITS:0] diff;

  always_comb begin
    trial = {rem_r, dvd_r[OPERAND_BITS-1]};
    diff  = trial - {1'b0, dsr_r};
  end

  always_comb begin
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNT_BITS'(OPERAND_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[OPERAND_BITS-2:0], 1'b0};
      // trial is below twice the divisor, so one subtract restores it
      rem_nxt = diff[OPERAND_BITS] ? trial[OPERAND_BITS-1:0] : diff[OPERAND_BITS-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

  `EGCD_ASSERT_SAME(a_start_idle, clk, rst_n, start, !busy_r)
  `EGCD_ASSERT_SAME(a_rem_below, clk, rst_n, done_r, rem_r < dsr_r)
  `EGCD_ASSERT_SAME(a_busy_cnt, clk, rst_n, busy_r, cnt_r != '0)

endmodule

// File: design/euclidean_gcd_unit.sv
// Greatest common divisor of two unsigned operands, Euclid's remainder form.
// Input channel: in_valid/in_ready with in_first_value and in_second_value.
// Result channel: out_valid/out_ready with out_divisor, one item per input.
// gcd(x, 0) = x and gcd(0, 0) = 0; operand order does not matter.
// One item is worked on at a time. Each remainder step is a test state, the
// bit-serial remainder unit (one dividend bit a cycle) and a swap of the pair
// when the remainder unit signals done. With 63-bit operands an item needs up
// to about ninety steps, and a few steps for typical data. The next item is
// taken once the result sits in the output register, so the receiver's stall
// delays input only when a second result is ready before the first has been
// taken.
// Reset (rst_n low, synchronous) returns to idle and drops out_valid;
// an item in flight is discarded.
`include "euclidean_gcd_unit_assert.svh"

module euclidean_gcd_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  egcd_pkg::operand_t in_first_value,
  input  egcd_pkg::operand_t in_second_value,
  output logic               out_valid,
  input  logic               out_ready,
  output egcd_pkg::operand_t out_divisor
);
  import egcd_pkg::*;

  state_t   state_r, state_nxt;
  operand_t a_r, a_nxt;
  operand_t b_r, b_nxt;
  operand_t res_r, res_nxt;
  logic     out_valid_r, out_valid_nxt;

  logic     b_zero;
  logic     in_take;
  logic     rem_start;
  logic     rem_done;
  operand_t rem_val;
  logic     res_load;

  egcd_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (rem_start),
    .dividend  (a_r),
    .divisor   (b_r),
    .done      (rem_done),
    .remainder (rem_val)
  );

  assign b_zero = (b_r == '0);

  // outputs of the controller
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    rem_start = (state_r == ST_TEST) && !b_zero;
    res_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  end

  assign in_take = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_TEST;
      ST_TEST: state_nxt = b_zero ? ST_DONE : ST_DIV;
      ST_DIV:  if (rem_done) state_nxt = ST_TEST;
      ST_DONE: if (res_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (in_take) begin
      a_nxt = in_first_value;
      b_nxt = in_second_value;
    end
    if (rem_done) begin
      a_nxt = b_r;
      b_nxt = rem_val;
    end
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (res_load) begin
      res_nxt       = a_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    res_r <= res_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_divisor = res_r;

  `EGCD_ASSERT_SAME(a_div_nonzero, clk, rst_n, state_r == ST_DIV, !b_zero)
  `EGCD_ASSERT_SAME(a_done_in_div, clk, rst_n, rem_done, state_r == ST_DIV)
  `EGCD_ASSERT_NEXT(a_take_test, clk, rst_n, in_take, state_r == ST_TEST)

endmodule
